@@ hdl/blake2b_sponge_duplex_macros.svh @@
// Assertion macros shared by the sponge duplex RTL.
`ifndef BLAKE2B_SPONGE_DUPLEX_MACROS_SVH
`define BLAKE2B_SPONGE_DUPLEX_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge out of reset.
`define B2SD_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked at every rising edge out of reset.
`define B2SD_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define B2SD_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define B2SD_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ hdl/b2sd_pkg.sv @@
// Types, constants and mixing functions of the sponge duplex engine.
package b2sd_pkg;

    typedef logic [63:0] t_word;
    typedef t_word [15:0] t_state;
    typedef t_word [7:0]  t_block;
    typedef t_word [3:0]  t_quad;

    typedef enum logic [3:0] {
        CMD_INIT         = 4'd0,
        CMD_ABSORB_FULL  = 4'd1,
        CMD_ABSORB_SALT  = 4'd2,
        CMD_ABSORB_RED   = 4'd3,
        CMD_SQUEEZE_FULL = 4'd4,
        CMD_SQUEEZE_RED  = 4'd5,
        CMD_DUPLEX_XOR   = 4'd6,
        CMD_DUPLEX_SETUP = 4'd7,
        CMD_PEEK         = 4'd8
    } t_cmd_e;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_ROUND = 2'd1,
        ST_EMIT  = 2'd2
    } t_fsm_e;

    // What happens to the result buffer when the permutation ends.
    typedef enum logic [1:0] {
        RES_NONE  = 2'd0,
        RES_HELD  = 2'd1,
        RES_XOR   = 2'd2,
        RES_STATE = 2'd3
    } t_res_e;

    localparam t_block IV_WORDS = '{
        64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b,
        64'h9b05688c2b3e6c1f, 64'h510e527fade682d1,
        64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b,
        64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908
    };

    localparam t_word SALT_PAD_LOW  = 64'h0000000000000080;
    localparam t_word SALT_PAD_HIGH = 64'h0100000000000000;

    function automatic t_state b2sd_reset_state();
        t_state s;
        for (int i = 0; i < 8; i++) begin
            s[i]     = '0;
            s[8 + i] = IV_WORDS[i];
        end
        return s;
    endfunction

    function automatic t_word b2sd_rotr(input t_word x, input logic [5:0] n);
        return (x >> n) | (x << (7'd64 - {1'b0, n}));
    endfunction

    // One Blake2b mixing function without message words.
    function automatic t_quad b2sd_g(input t_quad q);
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_quad r;
        a = q[0];
        b = q[1];
        c = q[2];
        d = q[3];
        a = a + b;
        d = b2sd_rotr(d ^ a, 6'd32);
        c = c + d;
        b = b2sd_rotr(b ^ c, 6'd24);
        a = a + b;
        d = b2sd_rotr(d ^ a, 6'd16);
        c = c + d;
        b = b2sd_rotr(b ^ c, 6'd63);
        r[0] = a;
        r[1] = b;
        r[2] = c;
        r[3] = d;
        return r;
    endfunction

endpackage

@@ hdl/b2sd_half_round.sv @@
// Half of one Blake2b round: four mixing functions on columns or diagonals.
module b2sd_half_round (
    input  b2sd_pkg::t_state i_state,
    input  logic             i_diag,
    output b2sd_pkg::t_state o_state
);
    import b2sd_pkg::*;

    always_comb begin
        logic [3:0] ia;
        logic [3:0] ib;
        logic [3:0] ic;
        logic [3:0] id;
        logic [1:0] sh;
        t_quad      q;
        t_quad      r;
        o_state = i_state;
        for (int i = 0; i < 4; i++) begin
            // Lane i takes word i, then steps one further right per row on diagonals.
            sh = {1'b0, i_diag};
            ia = 4'(i);
            ib = {2'b01, 2'(i) + sh};
            ic = {2'b10, 2'(i) + {sh[0], 1'b0}};
            id = {2'b11, 2'(i) + {sh[0], sh[0]}};
            q[0] = i_state[ia];
            q[1] = i_state[ib];
            q[2] = i_state[ic];
            q[3] = i_state[id];
            r = b2sd_g(q);
            o_state[ia] = r[0];
            o_state[ib] = r[1];
            o_state[ic] = r[2];
            o_state[id] = r[3];
        end
    end

endmodule

@@ hdl/blake2b_sponge_duplex.sv @@
// Top level of the Blake2b sponge duplex engine.
// A permuting command runs FULL_ROUNDS rounds, or one in reduced mode, each as a column
// half and then a diagonal half on the single half-round unit; a result then moves from
// the result buffer into the output register. No new beat is taken until the block is
// idle again; a peek only hands its result off, and an init or an unused code acts on acceptance.
// Reset (synchronous, active low) loads zeros and the IV into the state and empties the output.
module blake2b_sponge_duplex #(
    parameter int FULL_ROUNDS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [3:0]           i_cmd,
    input  b2sd_pkg::t_word      i_in_word0,
    input  b2sd_pkg::t_word      i_in_word1,
    input  b2sd_pkg::t_word      i_in_word2,
    input  b2sd_pkg::t_word      i_in_word3,
    input  b2sd_pkg::t_word      i_in_word4,
    input  b2sd_pkg::t_word      i_in_word5,
    input  b2sd_pkg::t_word      i_in_word6,
    input  b2sd_pkg::t_word      i_in_word7,
    output logic                 o_valid,
    input  logic                 i_stall,
    output b2sd_pkg::t_word      o_out_word0,
    output b2sd_pkg::t_word      o_out_word1,
    output b2sd_pkg::t_word      o_out_word2,
    output b2sd_pkg::t_word      o_out_word3,
    output b2sd_pkg::t_word      o_out_word4,
    output b2sd_pkg::t_word      o_out_word5,
    output b2sd_pkg::t_word      o_out_word6,
    output b2sd_pkg::t_word      o_out_word7
);
    import b2sd_pkg::*;

`include "blake2b_sponge_duplex_macros.svh"

    // The round counter must hold FULL_ROUNDS itself.
    localparam int ROUNDS_W = $clog2(FULL_ROUNDS + 1);
    localparam logic [ROUNDS_W-1:0] ROUNDS_FULL = ROUNDS_W'(FULL_ROUNDS);
    localparam logic [ROUNDS_W-1:0] ROUNDS_ONE  = ROUNDS_W'(1);

    // Sequencer state, sponge state and the round counter. r_diag selects the
    // diagonal half of the round; the counter drops after each diagonal half.
    t_fsm_e              r_state;
    t_fsm_e              n_state;
    t_state              r_sponge;
    t_state              n_sponge;
    logic [ROUNDS_W-1:0] r_rounds;
    logic [ROUNDS_W-1:0] n_rounds;
    logic                r_diag;
    logic                n_diag;

    // The result buffer holds the emitted words, taken before the permutation,
    // the input block waiting to be XORed with the new state, or the new rate words.
    t_block              r_res;
    t_block              n_res;
    t_res_e              r_res_kind;
    t_res_e              n_res_kind;

    // Output register; it frees the sequencer from the consumer's stalls.
    t_block              r_out_word;
    t_block              n_out_word;
    logic                r_out_valid;
    logic                n_out_valid;

    t_block              w_in;
    t_state              w_round;
    logic                w_out_free;

    assign w_in = {i_in_word7, i_in_word6, i_in_word5, i_in_word4,
                   i_in_word3, i_in_word2, i_in_word1, i_in_word0};

    // Input beats are taken only while the sequencer is idle.
    assign o_stall    = (r_state != ST_IDLE);
    assign w_out_free = !r_out_valid || !i_stall;

    b2sd_half_round u_half_round (
        .i_state (r_sponge),
        .i_diag  (r_diag),
        .o_state (w_round)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sponge    <= b2sd_reset_state();
            r_rounds    <= '0;
            r_diag      <= 1'b0;
            r_res_kind  <= RES_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sponge    <= n_sponge;
            r_rounds    <= n_rounds;
            r_diag      <= n_diag;
            r_res_kind  <= n_res_kind;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res      <= n_res;
        r_out_word <= n_out_word;
    end

    always_comb begin
        n_state     = r_state;
        n_sponge    = r_sponge;
        n_rounds    = r_rounds;
        n_diag      = r_diag;
        n_res       = r_res;
        n_res_kind  = r_res_kind;
        n_out_word  = r_out_word;
        n_out_valid = r_out_valid && i_stall;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_diag = 1'b0;
                    unique case (i_cmd) inside
                        CMD_INIT: begin
                            n_sponge = b2sd_reset_state();
                        end
                        CMD_ABSORB_FULL, CMD_ABSORB_RED, CMD_DUPLEX_XOR,
                        CMD_DUPLEX_SETUP: begin
                            // All four absorb the block into the rate words first.
                            for (int i = 0; i < 8; i++) begin
                                n_sponge[i] = r_sponge[i] ^ w_in[i];
                            end
                            n_state    = ST_ROUND;
                            n_rounds   = (i_cmd == CMD_ABSORB_FULL) ? ROUNDS_FULL
                                                                    : ROUNDS_ONE;
                            n_res      = w_in;
                            n_res_kind = (i_cmd == CMD_DUPLEX_XOR)   ? RES_XOR   :
                                         (i_cmd == CMD_DUPLEX_SETUP) ? RES_STATE :
                                                                       RES_NONE;
                        end
                        CMD_ABSORB_SALT: begin
                            n_sponge[0] = r_sponge[0] ^ w_in[0];
                            n_sponge[1] = r_sponge[1] ^ w_in[1];
                            n_sponge[2] = r_sponge[2] ^ SALT_PAD_LOW;
                            n_sponge[7] = r_sponge[7] ^ SALT_PAD_HIGH;
                            n_state     = ST_ROUND;
                            n_rounds    = ROUNDS_FULL;
                            n_res_kind  = RES_NONE;
                        end
                        CMD_SQUEEZE_FULL, CMD_SQUEEZE_RED: begin
                            // The emitted words are the state before permuting.
                            n_res      = r_sponge[7:0];
                            n_res_kind = RES_HELD;
                            n_state    = ST_ROUND;
                            n_rounds   = (i_cmd == CMD_SQUEEZE_FULL) ? ROUNDS_FULL
                                                                     : ROUNDS_ONE;
                        end
                        CMD_PEEK: begin
                            n_res      = r_sponge[7:0];
                            n_res_kind = RES_HELD;
                            n_state    = ST_EMIT;
                        end
                        default: begin
                            // Unused codes leave everything as it is.
                            n_res_kind = RES_NONE;
                        end
                    endcase
                end
            end
            ST_ROUND: begin
                n_sponge = w_round;
                n_diag   = !r_diag;
                if (r_diag) begin
                    n_rounds = r_rounds - ROUNDS_ONE;
                    if (r_rounds == ROUNDS_ONE) begin
                        // Last half round: finish the result from the new state.
                        case (r_res_kind)
                            RES_XOR: begin
                                for (int i = 0; i < 8; i++) begin
                                    n_res[i] = r_res[i] ^ w_round[i];
                                end
                            end
                            RES_STATE: begin
                                n_res = w_round[7:0];
                            end
                            default: begin
                                n_res = r_res;
                            end
                        endcase
                        n_state = (r_res_kind == RES_NONE) ? ST_IDLE : ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_out_word  = r_res;
                    n_out_valid = 1'b1;
                    n_res_kind  = RES_NONE;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_valid     = r_out_valid;
    assign o_out_word0 = r_out_word[0];
    assign o_out_word1 = r_out_word[1];
    assign o_out_word2 = r_out_word[2];
    assign o_out_word3 = r_out_word[3];
    assign o_out_word4 = r_out_word[4];
    assign o_out_word5 = r_out_word[5];
    assign o_out_word6 = r_out_word[6];
    assign o_out_word7 = r_out_word[7];

    // A full-mode command must start the permutation with the full round count.
    `B2SD_NEXT(a_full_start, i_clk, i_rst_n,
        i_valid && !o_stall && (i_cmd == CMD_ABSORB_FULL || i_cmd == CMD_ABSORB_SALT
            || i_cmd == CMD_SQUEEZE_FULL),
        r_state == ST_ROUND && r_rounds == ROUNDS_FULL && !r_diag,
        "full command did not start a full permutation")
    // The sequencer never permutes with an exhausted round counter.
    `B2SD_IMPLY(a_round_count, i_clk, i_rst_n, r_state == ST_ROUND, r_rounds != '0,
        "round counter empty while permuting")
    // Waiting to emit implies there is a result to emit.
    `B2SD_IMPLY(a_emit_kind, i_clk, i_rst_n, r_state == ST_EMIT, r_res_kind != RES_NONE,
        "emit state without a pending result")
    // Once the output register is free the result moves out and the block goes idle.
    `B2SD_NEXT(a_emit_done, i_clk, i_rst_n, r_state == ST_EMIT && w_out_free,
        r_out_valid && r_state == ST_IDLE, "result not delivered from emit state")

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the Blake2b sponge duplex engine with its own sponge predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import b2sd_pkg::*;

    localparam int FULL_ROUNDS = 12;

    // Number of beats in the random part that the block acts on (ignored codes do not count).
    localparam int RANDOM_BEATS = 1650;

    // Chance, in percent, that a side idles in a given cycle.
    localparam int IDLE_PCT = 29;

    // The quiet window, in accepted beats, where neither side idles at all.
    localparam int CALM_FIRST = 600;
    localparam int CALM_LAST  = 900;

    // The limit is far above the slowest correct run, even with both sides idling.
    localparam int LIMIT_CYCLES = 400000;

    // After the last result, an absorb with no result may still be running.
    localparam int DRAIN_CYCLES = 4 * FULL_ROUNDS + 8;

    // Only the first few mismatches are printed. All of them are counted.
    localparam int MAX_REPORTS = 30;

    // Codes 9 to 15 are not commands. The block must ignore them.
    localparam logic [3:0] CMD_FIRST_UNUSED = 4'd9;
    localparam logic [3:0] CMD_LAST_UNUSED  = 4'd15;

    // Blake2b initialization vector. Index 0 goes to sponge word 8.
    localparam t_word BLAKE_IV [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
        64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    // Padding that the salt absorb folds into words 2 and 7.
    localparam t_word SALT_PAD_FIRST = 64'h0000000000000080;
    localparam t_word SALT_PAD_LAST  = 64'h0100000000000000;

    typedef struct {
        logic [3:0] cmd;
        t_block     words;
    } t_beat;

    // Clock, reset and every input of the block start at a known value.
    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_valid    = 1'b0;
    logic [3:0] i_cmd      = '0;
    t_word      i_in_word0 = '0;
    t_word      i_in_word1 = '0;
    t_word      i_in_word2 = '0;
    t_word      i_in_word3 = '0;
    t_word      i_in_word4 = '0;
    t_word      i_in_word5 = '0;
    t_word      i_in_word6 = '0;
    t_word      i_in_word7 = '0;
    logic       i_stall    = 1'b0;

    logic  o_stall;
    logic  o_valid;
    t_word o_out_word0;
    t_word o_out_word1;
    t_word o_out_word2;
    t_word o_out_word3;
    t_word o_out_word4;
    t_word o_out_word5;
    t_word o_out_word6;
    t_word o_out_word7;

    blake2b_sponge_duplex #(
        .FULL_ROUNDS (FULL_ROUNDS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (i_cmd),
        .i_in_word0  (i_in_word0),
        .i_in_word1  (i_in_word1),
        .i_in_word2  (i_in_word2),
        .i_in_word3  (i_in_word3),
        .i_in_word4  (i_in_word4),
        .i_in_word5  (i_in_word5),
        .i_in_word6  (i_in_word6),
        .i_in_word7  (i_in_word7),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_word0 (o_out_word0),
        .o_out_word1 (o_out_word1),
        .o_out_word2 (o_out_word2),
        .o_out_word3 (o_out_word3),
        .o_out_word4 (o_out_word4),
        .o_out_word5 (o_out_word5),
        .o_out_word6 (o_out_word6),
        .o_out_word7 (o_out_word7)
    );

    // The data words of the current input beat and of the current result, as blocks.
    // Index i of a block is word i.
    t_block sent_words;
    t_block seen_words;
    assign sent_words = {i_in_word7, i_in_word6, i_in_word5, i_in_word4,
                         i_in_word3, i_in_word2, i_in_word1, i_in_word0};
    assign seen_words = {o_out_word7, o_out_word6, o_out_word5, o_out_word4,
                         o_out_word3, o_out_word2, o_out_word1, o_out_word0};

    t_beat  pending_q [$];   // beats still to be driven
    t_block squeeze_q [$];   // output blocks the block still owes, oldest first
    t_word  sponge [16];     // predicted sponge state
    int     accepted_beats = 0;
    int     mismatches     = 0;
    int     cycle_count    = 0;
    int     acted_beats    = 0;

    // Both sides run without any idling while the accepted count is inside the window.
    wire calm = (accepted_beats >= CALM_FIRST) && (accepted_beats < CALM_LAST);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Sponge predictor. The permutation is the Blake2b round with no
    // message words, applied to the sixteen-word state in place.
    // ------------------------------------------------------------------

    function automatic t_word rot_right(input t_word x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic void mix_quarter(input int a, input int b, input int c, input int d);
        sponge[a] = sponge[a] + sponge[b];
        sponge[d] = rot_right(sponge[d] ^ sponge[a], 32);
        sponge[c] = sponge[c] + sponge[d];
        sponge[b] = rot_right(sponge[b] ^ sponge[c], 24);
        sponge[a] = sponge[a] + sponge[b];
        sponge[d] = rot_right(sponge[d] ^ sponge[a], 16);
        sponge[c] = sponge[c] + sponge[d];
        sponge[b] = rot_right(sponge[b] ^ sponge[c], 63);
    endfunction

    // Columns first, then diagonals.
    function automatic void permute_sponge(input int rounds);
        for (int r = 0; r < rounds; r++) begin
            mix_quarter(0, 4, 8, 12);
            mix_quarter(1, 5, 9, 13);
            mix_quarter(2, 6, 10, 14);
            mix_quarter(3, 7, 11, 15);
            mix_quarter(0, 5, 10, 15);
            mix_quarter(1, 6, 11, 12);
            mix_quarter(2, 7, 8, 13);
            mix_quarter(3, 4, 9, 14);
        end
    endfunction

    function automatic void clear_sponge();
        for (int i = 0; i < 8; i++) begin
            sponge[i]     = '0;
            sponge[8 + i] = BLAKE_IV[i];
        end
    endfunction

    function automatic void absorb_block(input t_block din, input int rounds);
        for (int i = 0; i < 8; i++)
            sponge[i] = sponge[i] ^ din[i];
        permute_sponge(rounds);
    endfunction

    function automatic t_block rate_words();
        t_block w;
        for (int i = 0; i < 8; i++)
            w[i] = sponge[i];
        return w;
    endfunction

    // Applies one accepted beat to the predicted state. Returns 1 when the beat
    // gives an output block, which is then left in dout.
    function automatic bit predict_squeeze(input logic [3:0] cmd, input t_block din,
                                           output t_block dout);
        dout = '0;
        case (cmd)
            CMD_INIT: begin
                clear_sponge();
                return 1'b0;
            end
            CMD_ABSORB_FULL: begin
                absorb_block(din, FULL_ROUNDS);
                return 1'b0;
            end
            CMD_ABSORB_SALT: begin
                // Only the two salt words are taken; the rest of the beat is ignored.
                sponge[0] = sponge[0] ^ din[0];
                sponge[1] = sponge[1] ^ din[1];
                sponge[2] = sponge[2] ^ SALT_PAD_FIRST;
                sponge[7] = sponge[7] ^ SALT_PAD_LAST;
                permute_sponge(FULL_ROUNDS);
                return 1'b0;
            end
            CMD_ABSORB_RED: begin
                absorb_block(din, 1);
                return 1'b0;
            end
            CMD_SQUEEZE_FULL: begin
                dout = rate_words();
                permute_sponge(FULL_ROUNDS);
                return 1'b1;
            end
            CMD_SQUEEZE_RED: begin
                dout = rate_words();
                permute_sponge(1);
                return 1'b1;
            end
            CMD_DUPLEX_XOR: begin
                absorb_block(din, 1);
                dout = rate_words() ^ din;
                return 1'b1;
            end
            CMD_DUPLEX_SETUP: begin
                absorb_block(din, 1);
                dout = rate_words();
                return 1'b1;
            end
            CMD_PEEK: begin
                dout = rate_words();
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    function automatic t_word rand_word();
        return {$urandom, $urandom};
    endfunction

    // Mostly random data, with all-zero and all-one blocks now and then.
    function automatic t_block rand_block();
        t_block w;
        int pick;
        pick = $urandom_range(0, 99);
        for (int i = 0; i < 8; i++) begin
            if (pick < 5)
                w[i] = '0;
            else if (pick < 10)
                w[i] = '1;
            else
                w[i] = rand_word();
        end
        return w;
    endfunction

    function automatic t_block same_words(input t_word w);
        t_block b;
        for (int i = 0; i < 8; i++)
            b[i] = w;
        return b;
    endfunction

    function automatic void queue_beat(input logic [3:0] cmd, input t_block w);
        t_beat b;
        b.cmd   = cmd;
        b.words = w;
        pending_q.push_back(b);
        if (cmd <= CMD_PEEK)
            acted_beats++;
    endfunction

    // Each mismatch prints one line (up to a cap) and is counted.
    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_REPORTS)
            $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Driver. A beat is accepted at an edge where i_valid is high and
    // o_stall low; the predictor runs on the beat that was on the pins.
    // A stalled beat holds still. A new beat is only picked when the
    // current one was taken or there was none.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : sender
        t_block want_words;
        t_beat  next_beat;
        bit     gives_result;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            clear_sponge();
        end else begin
            if (i_valid && !o_stall) begin
                gives_result = predict_squeeze(i_cmd, sent_words, want_words);
                if (gives_result)
                    squeeze_q.push_back(want_words);
                accepted_beats <= accepted_beats + 1;
            end
            if (!i_valid || !o_stall) begin
                if (pending_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    next_beat = pending_q.pop_front();
                    i_valid    <= 1'b1;
                    i_cmd      <= next_beat.cmd;
                    i_in_word0 <= next_beat.words[0];
                    i_in_word1 <= next_beat.words[1];
                    i_in_word2 <= next_beat.words[2];
                    i_in_word3 <= next_beat.words[3];
                    i_in_word4 <= next_beat.words[4];
                    i_in_word5 <= next_beat.words[5];
                    i_in_word6 <= next_beat.words[6];
                    i_in_word7 <= next_beat.words[7];
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor. Every accepted result beat is checked word by word against
    // the oldest predicted block. The receiver stalls at random, outside
    // the quiet window.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : receiver
        t_block want_words;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (squeeze_q.size() == 0) begin
                    report_mismatch("result beat with no output block expected");
                end else begin
                    want_words = squeeze_q.pop_front();
                    for (int i = 0; i < 8; i++) begin
                        if (seen_words[i] !== want_words[i])
                            report_mismatch($sformatf("out_word%0d is %h, expected %h",
                                                      i, seen_words[i], want_words[i]));
                    end
                end
            end
            i_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Watchdog: a hung block ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : stimulus
        t_cmd_e body_cmds [6];
        int     n_absorb;
        int     n_body;
        int     target;

        body_cmds = '{CMD_SQUEEZE_FULL, CMD_SQUEEZE_RED, CMD_DUPLEX_XOR,
                      CMD_DUPLEX_SETUP, CMD_PEEK, CMD_ABSORB_RED};

        // Directed part. Peek straight after reset shows the cleared state,
        // then every command runs at least once, with all-zero, all-one, alternating or random data.
        queue_beat(CMD_PEEK, same_words('0));
        queue_beat(CMD_ABSORB_FULL, same_words('1));
        queue_beat(CMD_SQUEEZE_FULL, same_words('0));
        // Salt absorb with a random block and with an all-one block; the words past the salt are ignored.
        queue_beat(CMD_ABSORB_SALT, rand_block());
        queue_beat(CMD_ABSORB_SALT, same_words('1));
        queue_beat(CMD_SQUEEZE_RED, same_words('1));
        queue_beat(CMD_ABSORB_RED, same_words('0));
        queue_beat(CMD_DUPLEX_XOR, same_words('1));
        queue_beat(CMD_DUPLEX_SETUP, same_words(64'haaaaaaaaaaaaaaaa));
        queue_beat(CMD_DUPLEX_XOR, same_words(64'h5555555555555555));
        queue_beat(CMD_PEEK, same_words('1));
        // Unused codes must leave the state alone and give nothing.
        queue_beat(CMD_FIRST_UNUSED, same_words('1));
        queue_beat(CMD_LAST_UNUSED, same_words('1));
        queue_beat(CMD_PEEK, same_words('0));
        // Init in the middle of a session returns the state to its reset value.
        queue_beat(CMD_INIT, same_words('1));
        queue_beat(CMD_PEEK, same_words('0));
        queue_beat(CMD_DUPLEX_XOR, same_words('0));
        queue_beat(CMD_ABSORB_FULL, same_words('0));
        queue_beat(CMD_ABSORB_SALT, same_words('0));
        queue_beat(CMD_SQUEEZE_FULL, same_words('0));
        queue_beat(CMD_SQUEEZE_FULL, same_words('0));
        queue_beat(CMD_PEEK, same_words('0));

        // Random part. Most of it is hashing sessions: usually an init, perhaps a salt,
        // up to three absorbs and then a run of squeezes, duplexes, peeks and reduced absorbs.
        // The rest is noise over all sixteen codes.
        target = acted_beats + RANDOM_BEATS;
        while (acted_beats < target) begin
            if ($urandom_range(0, 99) < 85) begin
                if ($urandom_range(0, 99) < 80)
                    queue_beat(CMD_INIT, rand_block());
                if ($urandom_range(0, 1) == 1)
                    queue_beat(CMD_ABSORB_SALT, rand_block());
                n_absorb = $urandom_range(0, 3);
                for (int i = 0; i < n_absorb; i++)
                    queue_beat($urandom_range(0, 1) ? CMD_ABSORB_FULL : CMD_ABSORB_RED,
                               rand_block());
                n_body = $urandom_range(1, 8);
                for (int i = 0; i < n_body; i++)
                    queue_beat(body_cmds[$urandom_range(0, 5)], rand_block());
            end else begin
                queue_beat(4'($urandom_range(0, 15)), rand_block());
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every beat is taken and every output block has come back.
        // The check runs at the falling edge, once the driver's updates have settled.
        while (pending_q.size() != 0 || i_valid || squeeze_q.size() != 0)
            @(negedge i_clk);
        // Let a trailing absorb finish and catch any stray result beat.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && squeeze_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/b2sd_pkg.sv
hdl/b2sd_half_round.sv
hdl/blake2b_sponge_duplex.sv
tb/tb.sv
